// ===== rtl/core/char_display_nibble_sequencer_macros.svh =====
// Assertion macros for the character display nibble sequencer.
// Used by the checker; no other dependencies.
`ifndef CHAR_DISPLAY_NIBBLE_SEQUENCER_MACROS_SVH
`define CHAR_DISPLAY_NIBBLE_SEQUENCER_MACROS_SVH

// Implication checked at every rising edge, skipped while reset is high.
`define CDNS_ASSERT_SYNC(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check, also evaluated while reset is high.
`define CDNS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/cdns_pkg.sv =====
// Types, codes and the power-up transfer table of the nibble sequencer.
// No dependencies.
package cdns_pkg;

   localparam int STEP_W   = 5;
   localparam int INIT_LEN = 17;

   typedef logic [STEP_W-1:0] cdns_step_type;

   typedef enum logic [2:0] {
      CMD_INIT  = 3'd0,
      CMD_RAW   = 3'd1,
      CMD_DATA  = 3'd2,
      CMD_GOTO  = 3'd3,
      CMD_CLEAR = 3'd4,
      CMD_HOME  = 3'd5
   } cdns_cmd_type;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] value;
      logic       row;
      logic [7:0] column;
   } cdns_req_type;

   typedef struct packed {
      logic        reg_select;
      logic [3:0]  nibble;
      logic        strobe_res;
      logic [15:0] wait_us;
      logic        last;
   } cdns_rsp_type;

   // One queued job: either the power-up sequence or one byte transfer.
   typedef struct packed {
      logic        is_init;
      logic        reg_select;
      logic [7:0]  byte_val;
      logic [15:0] wait_us;
   } cdns_job_type;

   localparam logic        RS_CMD      = 1'b0;
   localparam logic        RS_DATA     = 1'b1;
   localparam logic [15:0] WAIT_RAW    = 16'd100;
   localparam logic [15:0] WAIT_DATA   = 16'd50;
   localparam logic [15:0] WAIT_GOTO   = 16'd50;
   localparam logic [15:0] WAIT_CLEAR  = 16'd3000;
   localparam logic [15:0] WAIT_HOME   = 16'd3000;
   localparam logic [7:0]  BYTE_CLEAR  = 8'h01;
   localparam logic [7:0]  BYTE_HOME   = 8'h02;
   localparam logic [6:0]  ROW2_OFFSET = 7'h40;

   // Power-up sequence, one transfer per step.
   function automatic cdns_rsp_type init_step(input cdns_step_type idx);
      cdns_rsp_type r;
      r            = '0;
      r.reg_select = RS_CMD;
      r.strobe_res = 1'b1;
      unique case (idx)
         5'd0: begin
            r.strobe_res = 1'b0;
            r.wait_us    = 16'd50000;
         end
         5'd1:  begin r.nibble = 4'h3; r.wait_us = 16'd5000; end
         5'd2:  begin r.nibble = 4'h3; r.wait_us = 16'd150;  end
         5'd3:  begin r.nibble = 4'h3; r.wait_us = 16'd150;  end
         5'd4:  begin r.nibble = 4'h2; r.wait_us = 16'd150;  end
         5'd5:  begin r.nibble = 4'h2; r.wait_us = 16'd0;    end
         5'd6:  begin r.nibble = 4'h8; r.wait_us = 16'd100;  end
         5'd7:  begin r.nibble = 4'h1; r.wait_us = 16'd0;    end
         5'd8:  begin r.nibble = 4'h3; r.wait_us = 16'd200;  end
         5'd9:  begin r.nibble = 4'h0; r.wait_us = 16'd0;    end
         5'd10: begin r.nibble = 4'h8; r.wait_us = 16'd100;  end
         5'd11: begin r.nibble = 4'h0; r.wait_us = 16'd0;    end
         5'd12: begin r.nibble = 4'h1; r.wait_us = 16'd3000; end
         5'd13: begin r.nibble = 4'h0; r.wait_us = 16'd0;    end
         5'd14: begin r.nibble = 4'h6; r.wait_us = 16'd100;  end
         5'd15: begin r.nibble = 4'h0; r.wait_us = 16'd0;    end
         5'd16: begin r.nibble = 4'hC; r.wait_us = 16'd100; r.last = 1'b1; end
         default: begin
            r.nibble  = 4'h0;
            r.wait_us = 16'd0;
            r.last    = 1'b1;
         end
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/cdns_fifo.sv =====
// Small register queue, used between front and back and on the result side.
// No package dependencies.
module cdns_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// ===== rtl/core/cdns_front.sv =====
// Request decode: turns a display request into one queued job, or none for unused codes.
// Depends on cdns_pkg.
module cdns_front #(
   parameter int LAST_COLUMN = 15
) (
   input  cdns_pkg::cdns_req_type req_item,
   output logic                   job_valid,
   output cdns_pkg::cdns_job_type job
);
   import cdns_pkg::*;

   logic [7:0] col_clamp;
   logic [6:0] ddram_addr;

   assign col_clamp  = (req_item.column > 8'(LAST_COLUMN)) ? 8'(LAST_COLUMN)
                                                           : req_item.column;
   assign ddram_addr = (req_item.row ? ROW2_OFFSET : 7'h00) + col_clamp[6:0];

   always_comb begin
      job_valid      = 1'b1;
      job.is_init    = 1'b0;
      job.reg_select = RS_CMD;
      job.byte_val   = req_item.value;
      job.wait_us    = WAIT_RAW;
      unique case (req_item.command)
         CMD_INIT: begin
            job.is_init = 1'b1;
         end
         CMD_RAW: begin
            job.wait_us = WAIT_RAW;
         end
         CMD_DATA: begin
            job.reg_select = RS_DATA;
            job.wait_us    = WAIT_DATA;
         end
         CMD_GOTO: begin
            job.byte_val = {1'b1, ddram_addr};   // set DDRAM address
            job.wait_us  = WAIT_GOTO;
         end
         CMD_CLEAR: begin
            job.byte_val = BYTE_CLEAR;
            job.wait_us  = WAIT_CLEAR;
         end
         CMD_HOME: begin
            job.byte_val = BYTE_HOME;
            job.wait_us  = WAIT_HOME;
         end
         default: begin
            job_valid = 1'b0;                    // unused codes are dropped
         end
      endcase
   end

endmodule

// ===== rtl/core/cdns_back.sv =====
// Transfer sequencer: walks one job into nibble transfers, one per cycle when not out_full.
// Depends on cdns_pkg.
module cdns_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   input  cdns_pkg::cdns_job_type job,
   output logic                   job_pop,
   input  logic                   out_full,
   output logic                   emit,
   output cdns_pkg::cdns_rsp_type xfer
);
   import cdns_pkg::*;

   cdns_step_type step_ff, step_in;

   always_comb begin
      if (job.is_init) begin
         xfer = init_step(step_ff);
      end else begin
         xfer.reg_select = job.reg_select;
         xfer.strobe_res = 1'b1;
         if (step_ff == '0) begin
            xfer.nibble  = job.byte_val[7:4];
            xfer.wait_us = '0;
            xfer.last    = 1'b0;
         end else begin
            xfer.nibble  = job.byte_val[3:0];
            xfer.wait_us = job.wait_us;
            xfer.last    = 1'b1;
         end
      end
   end

   assign emit    = job_valid && !out_full;
   assign job_pop = emit && xfer.last;

   always_comb begin
      step_in = step_ff;
      if (emit) begin
         step_in = xfer.last ? '0 : step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

// ===== rtl/core/char_display_nibble_sequencer.sv =====
// Top level of the character display nibble sequencer (4-bit bus).
// Depends on cdns_pkg, cdns_front, cdns_fifo, cdns_back.
//
//   channel   ports                        direction  payload
//   request   push, full, req_item         in         cdns_req_type
//   transfer  empty, pop, rsp_item         out        cdns_rsp_type
//
// One bus transfer leaves per cycle while the result queue has room; the step
// counter walks a byte into 2 transfers, init into 17; unused codes give none.
// Front decodes into a 2-deep job queue; back drains it into a 2-deep
// result queue, so either side stalls on its own.
// Reset is synchronous and empties both queues and the step counter.
module char_display_nibble_sequencer #(
   parameter int LAST_COLUMN = 15
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  cdns_pkg::cdns_req_type req_item,
   output logic                   empty,
   input  logic                   pop,
   output cdns_pkg::cdns_rsp_type rsp_item
);
   import cdns_pkg::*;

   localparam int JOB_DEPTH = 2;
   localparam int OUT_DEPTH = 2;

   // front -> job queue
   logic         dec_valid;
   cdns_job_type dec_job;
   logic         job_full;

   // job queue -> back
   logic         job_empty;
   logic         job_pop;
   cdns_job_type job_head;

   // back -> result queue
   logic         emit;
   logic         out_full;
   cdns_rsp_type xfer;

   assign full = job_full;

   cdns_front #(
      .LAST_COLUMN(LAST_COLUMN)
   ) u_front (
      .req_item (req_item),
      .job_valid(dec_valid),
      .job      (dec_job)
   );

   // Requests with unused codes are accepted and vanish here.
   cdns_fifo #(
      .WIDTH($bits(cdns_job_type)),
      .DEPTH(JOB_DEPTH)
   ) u_job_q (
      .clock(clock),
      .reset(reset),
      .push (push && dec_valid),
      .din  (dec_job),
      .full (job_full),
      .pop  (job_pop),
      .dout (job_head),
      .empty(job_empty)
   );

   cdns_back u_back (
      .clock    (clock),
      .reset    (reset),
      .job_valid(!job_empty),
      .job      (job_head),
      .job_pop  (job_pop),
      .out_full (out_full),
      .emit     (emit),
      .xfer     (xfer)
   );

   // Result queue: keeps the sequencer running while the consumer stalls, until it fills.
   cdns_fifo #(
      .WIDTH($bits(cdns_rsp_type)),
      .DEPTH(OUT_DEPTH)
   ) u_out_q (
      .clock(clock),
      .reset(reset),
      .push (emit),
      .din  (xfer),
      .full (out_full),
      .pop  (pop),
      .dout (rsp_item),
      .empty(empty)
   );

endmodule

// ===== rtl/core/cdns_checker.sv =====
// Port-level checks on the nibble sequencer, bound to the top level.
// Depends on cdns_pkg and char_display_nibble_sequencer_macros.svh.
`include "char_display_nibble_sequencer_macros.svh"

module cdns_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   full,
   input logic                   empty,
   input logic                   pop,
   input cdns_pkg::cdns_rsp_type rsp_item
);
   import cdns_pkg::*;

   // a stalled transfer holds
   `CDNS_ASSERT_SYNC(a_rsp_hold, clock, reset,
      (!empty && !pop) |=> (!empty && $stable(rsp_item)),
      "stalled transfer changed")

   // result queue comes out of reset empty, job queue not full
   `CDNS_ASSERT_ALWAYS(a_reset_empty, clock,
      $past(reset) |-> (empty && !full),
      "not empty after reset")

   // the only transfer without strobe is the power-up wait
   `CDNS_ASSERT_SYNC(a_wait_only, clock, reset,
      (!empty && !rsp_item.strobe_res) |-> (rsp_item.wait_us == 16'd50000 &&
         rsp_item.nibble == 4'h0 && !rsp_item.last && rsp_item.reg_select == RS_CMD),
      "bad wait-only transfer")

   // data writes strobe; high-nibble transfer waits 0, low-nibble one the data wait
   `CDNS_ASSERT_SYNC(a_data_wait, clock, reset,
      (!empty && rsp_item.reg_select == RS_DATA) |-> (rsp_item.strobe_res &&
         (rsp_item.last ? rsp_item.wait_us == WAIT_DATA : rsp_item.wait_us == 16'd0)),
      "bad data transfer")

   // a popped data transfer that ends its request pulses the strobe
   `CDNS_ASSERT_SYNC(a_no_empty_mid, clock, reset,
      (!empty && pop && rsp_item.last && rsp_item.reg_select == RS_DATA) |->
         rsp_item.strobe_res,
      "data last without strobe")

endmodule

bind char_display_nibble_sequencer cdns_checker u_cdns_checker (.*);

// ===== tb/sv/tb.sv =====
// Self-checking bench for char_display_nibble_sequencer.
// Depends on cdns_pkg for the request and transfer structs and the request codes.
// Predicts every 4-bit bus transfer and checks each one as it is popped.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cdns_pkg::*;

   // Codes that no request uses; the block must drop them without output.
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;

   localparam int GOTO_LAST_COLUMN = 15;

   // Hold times in microseconds, per request kind.
   localparam logic [15:0] HOLD_RAW   = 16'd100;
   localparam logic [15:0] HOLD_DATA  = 16'd50;
   localparam logic [15:0] HOLD_GOTO  = 16'd50;
   localparam logic [15:0] HOLD_CLEAR = 16'd3000;
   localparam logic [15:0] HOLD_HOME  = 16'd3000;

   // Power-up sequence content.
   localparam logic [15:0] HOLD_POWER_UP   = 16'd50000;
   localparam logic [15:0] HOLD_FIRST_WAKE = 16'd5000;
   localparam logic [15:0] HOLD_WAKE       = 16'd150;
   localparam logic [3:0]  NIB_WAKE        = 4'h3;
   localparam logic [3:0]  NIB_FOUR_BIT    = 4'h2;
   localparam logic [7:0]  SET_FUNCTION    = 8'h28;
   localparam logic [7:0]  SET_SHIFT       = 8'h13;
   localparam logic [7:0]  SET_DISPLAY_OFF = 8'h08;
   localparam logic [7:0]  SET_CLEAR       = 8'h01;
   localparam logic [7:0]  SET_ENTRY_MODE  = 8'h06;
   localparam logic [7:0]  SET_DISPLAY_ON  = 8'h0C;
   localparam logic [7:0]  SET_HOME        = 8'h02;
   localparam logic [7:0]  DDRAM_ADDR_CMD  = 8'h80;
   localparam logic [7:0]  SECOND_ROW_BASE = 8'h40;

   localparam int RESET_CYCLES    = 12;
   localparam int PRESSURE_AFTER  = 120;   // transfers popped before the long hold
   localparam int PRESSURE_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 40;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int RANDOM_REQUESTS = 330;
   localparam int MAX_PRINTED     = 40;

   // Expected-transfer book: expands each accepted request into its bus transfers
   // and checks popped transfers in order against them.
   class display_transfer_book;
      cdns_rsp_type due_transfers[$];
      int mismatches;
      int n_requests;
      int n_init;
      int n_ignored;
      int n_checked;

      function new();
         mismatches = 0;
         n_requests = 0;
         n_init     = 0;
         n_ignored  = 0;
         n_checked  = 0;
      endfunction

      function int outstanding();
         return due_transfers.size();
      endfunction

      function void add_transfer(logic rs, logic [3:0] nib, logic strobe, logic [15:0] hold);
         cdns_rsp_type t;
         t.reg_select = rs;
         t.nibble     = nib;
         t.strobe_res = strobe;
         t.wait_us    = hold;
         t.last       = 1'b0;
         due_transfers.push_back(t);
      endfunction

      // High nibble carries no hold; the low nibble carries the request's hold.
      function void add_byte(logic rs, logic [7:0] b, logic [15:0] hold);
         add_transfer(rs, b[7:4], 1'b1, 16'd0);
         add_transfer(rs, b[3:0], 1'b1, hold);
      endfunction

      function void note_request(cdns_req_type r);
         int          before_count;
         logic [7:0]  col;
         logic [7:0]  addr;
         cdns_rsp_type tail;
         before_count = due_transfers.size();
         n_requests++;
         case (r.command)
            CMD_INIT: begin
               n_init++;
               add_transfer(RS_CMD, 4'h0, 1'b0, HOLD_POWER_UP);
               add_transfer(RS_CMD, NIB_WAKE, 1'b1, HOLD_FIRST_WAKE);
               add_transfer(RS_CMD, NIB_WAKE, 1'b1, HOLD_WAKE);
               add_transfer(RS_CMD, NIB_WAKE, 1'b1, HOLD_WAKE);
               add_transfer(RS_CMD, NIB_FOUR_BIT, 1'b1, HOLD_WAKE);
               add_byte(RS_CMD, SET_FUNCTION, 16'd100);
               add_byte(RS_CMD, SET_SHIFT, 16'd200);
               add_byte(RS_CMD, SET_DISPLAY_OFF, 16'd100);
               add_byte(RS_CMD, SET_CLEAR, 16'd3000);
               add_byte(RS_CMD, SET_ENTRY_MODE, 16'd100);
               add_byte(RS_CMD, SET_DISPLAY_ON, 16'd100);
            end
            CMD_RAW:   add_byte(RS_CMD, r.value, HOLD_RAW);
            CMD_DATA:  add_byte(RS_DATA, r.value, HOLD_DATA);
            CMD_GOTO: begin
               col  = (r.column > GOTO_LAST_COLUMN) ? 8'(GOTO_LAST_COLUMN) : r.column;
               addr = (r.row ? SECOND_ROW_BASE : 8'h00) + col;
               add_byte(RS_CMD, DDRAM_ADDR_CMD | addr, HOLD_GOTO);
            end
            CMD_CLEAR: add_byte(RS_CMD, SET_CLEAR, HOLD_CLEAR);
            CMD_HOME:  add_byte(RS_CMD, SET_HOME, HOLD_HOME);
            default:   n_ignored++;
         endcase
         if (due_transfers.size() > before_count) begin
            tail      = due_transfers.pop_back();
            tail.last = 1'b1;
            due_transfers.push_back(tail);
         end
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= MAX_PRINTED)
            $display("[%0t] mismatch %0d: %s", $realtime, mismatches, what);
      endtask

      task check_transfer(cdns_rsp_type got);
         cdns_rsp_type want;
         if (due_transfers.size() == 0) begin
            report_mismatch($sformatf("transfer %h popped with nothing expected", got));
         end else begin
            want = due_transfers.pop_front();
            n_checked++;
            if (got.reg_select !== want.reg_select)
               report_mismatch($sformatf("reg_select got %b want %b",
                                         got.reg_select, want.reg_select));
            if (got.nibble !== want.nibble)
               report_mismatch($sformatf("nibble got %h want %h", got.nibble, want.nibble));
            if (got.strobe_res !== want.strobe_res)
               report_mismatch($sformatf("strobe_res got %b want %b",
                                         got.strobe_res, want.strobe_res));
            if (got.wait_us !== want.wait_us)
               report_mismatch($sformatf("wait_us got %0d want %0d", got.wait_us, want.wait_us));
            if (got.last !== want.last)
               report_mismatch($sformatf("last got %b want %b", got.last, want.last));
         end
      endtask
   endclass

   logic         clock;
   logic         reset;
   logic         push;
   logic         full;
   cdns_req_type req_item;
   logic         empty;
   logic         pop;
   cdns_rsp_type rsp_item;

   display_transfer_book book;

   int requests_offered;   // drives the sender's burst pattern
   int transfers_seen;     // drives the receiver's burst pattern and the long hold
   int idle_cycles;
   bit pressure_done;

   char_display_nibble_sequencer DUT (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Monitor: every transfer on either side is seen at the rising edge, before any
   // nonblocking update of this step lands, so the sampled values are the pre-edge ones.
   // Requests are expanded first; a transfer can never leave on the edge its request enters.
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full)
            book.note_request(req_item);
         if (pop && !empty) begin
            book.check_transfer(rsp_item);
            transfers_seen++;
         end
         // Watchdog: only cycles in which neither side moves count toward the limit.
         if ((push && !full) || (pop && !empty))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles, %0d still expected",
                     WATCHDOG_LIMIT, book.outstanding());
            $display("FAIL char_display_nibble_sequencer");
            $finish;
         end
      end
   end

   function automatic cdns_req_type req_of(logic [2:0] cmd, logic [7:0] val, logic r,
                                           logic [7:0] col);
      cdns_req_type q;
      q.command = cmd;
      q.value   = val;
      q.row     = r;
      q.column  = col;
      return q;
   endfunction

   // Sender: random idle gap before each request, except during burst stretches.
   // Push stays high across back-to-back requests so only one assignment per step.
   task automatic send_request(cdns_req_type q);
      int gap;
      gap = (((requests_offered / 40) % 3) == 1) ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push     <= 1'b1;
      req_item <= q;
      do @(posedge clock); while (full);
      requests_offered++;
   endtask

   // Receiver: random stall before each transfer, stretches with no stall,
   // and once a long hold so the block backs up and pushes back on the sender.
   task automatic run_receiver();
      int stall;
      forever begin
         if (!pressure_done && transfers_seen >= PRESSURE_AFTER) begin
            pressure_done = 1'b1;
            pop <= 1'b0;
            repeat (PRESSURE_CYCLES) @(posedge clock);
         end
         stall = (((transfers_seen / 60) % 3) == 2) ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
      end
   endtask

   initial begin
      int          valid_sent;
      int          pick;
      logic [2:0]  cmd;
      logic [7:0]  col;

      book             = new();
      requests_offered = 0;
      transfers_seen   = 0;
      idle_cycles      = 0;
      pressure_done    = 1'b0;
      reset            = 1'b1;
      push             = 1'b0;
      pop              = 1'b0;
      req_item         = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      fork
         run_receiver();
      join_none

      // Directed part: power-up sequence, byte extremes, goto clamping on both rows,
      // clear and home, unused codes, and unused fields set to their extremes.
      send_request(req_of(CMD_INIT, 8'hFF, 1'b1, 8'hFF));
      send_request(req_of(CMD_RAW, 8'h00, 1'b0, 8'h00));
      send_request(req_of(CMD_RAW, 8'hFF, 1'b1, 8'hFF));
      send_request(req_of(CMD_DATA, 8'h00, 1'b1, 8'hFF));
      send_request(req_of(CMD_DATA, 8'hFF, 1'b0, 8'h00));
      send_request(req_of(CMD_DATA, 8'hA5, 1'b0, 8'h5A));
      send_request(req_of(CMD_GOTO, 8'hFF, 1'b0, 8'h00));
      send_request(req_of(CMD_GOTO, 8'h00, 1'b1, 8'd15));
      send_request(req_of(CMD_GOTO, 8'h00, 1'b1, 8'd16));   // just past the last column
      send_request(req_of(CMD_GOTO, 8'h00, 1'b0, 8'hFF));   // far past, clamps
      send_request(req_of(CMD_GOTO, 8'h3C, 1'b1, 8'd7));
      send_request(req_of(CMD_CLEAR, 8'hFF, 1'b1, 8'hFF));
      send_request(req_of(CMD_HOME, 8'hFF, 1'b1, 8'hFF));
      send_request(req_of(CMD_SPARE_6, 8'hFF, 1'b1, 8'hFF));
      send_request(req_of(CMD_SPARE_7, 8'h00, 1'b0, 8'h00));
      send_request(req_of(CMD_RAW, 8'h5A, 1'b0, 8'h80));
      send_request(req_of(CMD_INIT, 8'h00, 1'b0, 8'h00));
      send_request(req_of(CMD_DATA, 8'h3C, 1'b1, 8'd15));

      // Random part: mostly byte-level requests with random content, now and then a
      // power-up sequence, a few unused codes that do not count toward the total.
      // Columns lean toward the clamp boundary but sweep the whole byte too.
      valid_sent = 0;
      while (valid_sent < RANDOM_REQUESTS) begin
         pick = $urandom_range(0, 99);
         if (pick < 3)
            cmd = CMD_INIT;
         else if (pick < 7)
            cmd = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
         else
            cmd = 3'($urandom_range(int'(CMD_RAW), int'(CMD_HOME)));
         col = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 20));
         send_request(req_of(cmd, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), col));
         if (cmd != CMD_SPARE_6 && cmd != CMD_SPARE_7)
            valid_sent++;
      end
      push <= 1'b0;

      // Drain: wait for every expected transfer, then give the block time to show
      // anything extra. The watchdog bounds both waits.
      while (book.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests (%0d power-up, %0d unused codes), %0d transfers checked",
               book.n_requests, book.n_init, book.n_ignored, book.n_checked);
      $display("random gaps and stalls on both sides, plus one %0d-cycle receiver hold",
               PRESSURE_CYCLES);
      if (book.mismatches == 0 && book.outstanding() == 0)
         $display("PASS char_display_nibble_sequencer");
      else
         $display("FAIL char_display_nibble_sequencer");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/cdns_pkg.sv
rtl/core/cdns_fifo.sv
rtl/core/cdns_front.sv
rtl/core/cdns_back.sv
rtl/core/char_display_nibble_sequencer.sv
rtl/core/cdns_checker.sv
tb/sv/tb.sv
